@@ sv/isrt_pkg.sv @@
// Package for the insertion sorter: depth, item payload types and the
// structs that pass between the sorting cells. No dependencies.
package isrt_pkg;

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
  } out_item_t;

  // What every cell sees in a cycle: an insertion of value, or a shift down.
  typedef struct packed {
    logic               insert;
    logic               shift;
    logic signed [31:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               gt;
  } cell_stat_t;

endpackage

@@ sv/insertion_sorter_top.sv @@
// Top level of the insertion sorter: a chain of DEPTH cells and the flush control.
// Depends on isrt_pkg and isrt_cell.
//
// Stable ascending sort of sets of signed 32-bit values. While a set loads, one
// item is taken every cycle: each value is compared against all cells at once
// and is in place in the following cycle. An item marked last, or the DEPTH-th
// item, starts the flush: the chain shifts toward cell 0 and one sorted item
// leaves per cycle through the output register unless the output stalls, the
// final one marked. Input is stalled for the flush, which runs until the set
// has drained; the single output port popping cell 0 sets the drain rate.
module insertion_sorter_top import isrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cell_cmd_t         cmd;
  cell_stat_t        stat [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic              in_acc, pop;
  logic              flushing_q, flushing_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  assign in_acc = in_valid_i && !in_stall_o;
  assign pop    = flushing_q && (!out_valid_q || !out_stall_i);

  assign cmd = '{insert: in_acc, shift: pop, value: in_data_i.value};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_stat_t left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = stat[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right = '0;
    end else begin : g_right
      assign right = stat[i+1];
    end
    isrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .stat_o  (stat[i])
    );
    assign vld[i] = stat[i].valid;
  end

  always_comb begin
    flushing_d = flushing_q;
    // The cell below the top being filled means this item fills the store.
    if (in_acc && (in_data_i.last || vld[DEPTH-2])) begin
      flushing_d = 1'b1;
    end else if (pop && !vld[1]) begin
      flushing_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_data_d  = '{sorted_value: stat[0].value, final_res: !vld[1]};
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flushing_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flushing_q  <= flushing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = flushing_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Occupied cells always form a run starting at cell 0.
  a_vld_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & (vld + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  // A flush never runs on an empty chain.
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> vld[0])
    else $error("flush with empty chain");

  // No item is inserted into a full chain.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !vld[DEPTH-1])
    else $error("insertion into full chain");

  // A last item starts a flush.
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last) |=> flushing_q)
    else $error("last item did not start a flush");

  // Popping the final entry ends the flush and empties the chain.
  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !vld[1]) |=> (!flushing_q && !vld[0]))
    else $error("flush did not end after final item");

endmodule

@@ sv/isrt_cell.sv @@
// One cell of the sorting chain: holds one entry of the sorted set.
// Depends on isrt_pkg.
module isrt_cell import isrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  cell_stat_t left_i,
  input  cell_stat_t right_i,
  output cell_stat_t stat_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;
  logic               gt;

  // An empty cell counts as larger than any value, so new entries fill upward.
  assign gt = !valid_q || (value_q > cmd_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end else if (cmd_i.insert && gt) begin
      // Entries strictly greater move up one place; the value takes the gap.
      if (left_i.gt) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign stat_o = '{valid: valid_q, value: value_q, gt: gt};

endmodule
